// ----- hdl/mm4_pkg.sv -----
// Shared constants, codes and command/status types for the 4x4 matrix multiplier.
package mm4_pkg;

   // Element format: signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction bits
   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int FIELD_WIDTH = 32;
   localparam int CMD_WIDTH   = 2;

   // Matrix geometry
   localparam int DIM         = 4;
   localparam int CELLS       = DIM * DIM;
   localparam int DIM_BITS    = $clog2(DIM);
   localparam int INDEX_WIDTH = $clog2(CELLS);

   // Datapath widths: exact product, exact sum of DIM products
   localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + DIM_BITS;

   // Command codes on the request channel
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE_LEFT  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE_RIGHT = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_MULTIPLY    = 2'd2;

   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(CELLS - 1);
   localparam logic [DIM_BITS-1:0]    LAST_K     = DIM_BITS'(DIM - 1);

   // Controller to datapath
   typedef struct packed {
      logic                   wr_left;
      logic                   wr_right;
      logic [INDEX_WIDTH-1:0] wr_index;
      logic                   rd_en;
      logic [INDEX_WIDTH-1:0] rd_left_addr;
      logic [INDEX_WIDTH-1:0] rd_right_addr;
      logic                   first;
      logic                   final_term;
      logic [INDEX_WIDTH-1:0] out_index;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sum_ready;
   } status_type;

endpackage

// ----- hdl/mm4_datapath.sv -----
// Datapath: element stores, multiply-accumulate pipeline, saturation and result register.
module mm4_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mm4_pkg::cmd_type                     cmd,
   input  logic signed [mm4_pkg::FIELD_WIDTH-1:0] req_element_value,
   output mm4_pkg::status_type                  status,
   output logic [mm4_pkg::INDEX_WIDTH-1:0]      rsp_result_index,
   output logic signed [mm4_pkg::FIELD_WIDTH-1:0] rsp_result_value,
   output logic                                 rsp_last
);
   import mm4_pkg::*;

   localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic [DATA_WIDTH-1:0] left_mem  [CELLS];
   logic [DATA_WIDTH-1:0] right_mem [CELLS];

   logic signed [DATA_WIDTH-1:0] a_ff, b_ff;
   logic                         v1_ff, first1_ff, final1_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic                         v2_ff, first2_ff, final2_ff;
   logic signed [SUM_WIDTH-1:0]  acc_ff;
   logic                         done_ff;

   logic signed [SUM_WIDTH-1:0]       shifted;
   logic [SUM_WIDTH-DATA_WIDTH:0]     upper;
   logic signed [DATA_WIDTH-1:0]      sat_value;

   logic [INDEX_WIDTH-1:0]          out_index_ff;
   logic signed [FIELD_WIDTH-1:0]   out_value_ff;
   logic                            out_last_ff;

   // Element stores: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (cmd.wr_left) begin
         left_mem[cmd.wr_index] <= req_element_value[DATA_WIDTH-1:0];
      end
      if (cmd.wr_right) begin
         right_mem[cmd.wr_index] <= req_element_value[DATA_WIDTH-1:0];
      end
      if (cmd.rd_en) begin
         a_ff <= left_mem[cmd.rd_left_addr];
         b_ff <= right_mem[cmd.rd_right_addr];
      end
   end

   // Pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= cmd.rd_en;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff && final2_ff;
      end
   end

   // Multiply stage, then accumulate stage
   always_ff @(posedge clock) begin
      first1_ff <= cmd.first;
      final1_ff <= cmd.final_term;
      first2_ff <= first1_ff;
      final2_ff <= final1_ff;
      prod_ff   <= a_ff * b_ff;
      if (v2_ff) begin
         if (first2_ff) begin
            acc_ff <= SUM_WIDTH'(prod_ff);
         end else begin
            acc_ff <= acc_ff + SUM_WIDTH'(prod_ff);
         end
      end
   end

   // Drop fraction bits (floor), saturate when the upper bits are not a sign extension
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      upper   = shifted[SUM_WIDTH-1:DATA_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         sat_value = shifted[DATA_WIDTH-1:0];
      end else if (shifted[SUM_WIDTH-1]) begin
         sat_value = SAT_MIN;
      end else begin
         sat_value = SAT_MAX;
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (done_ff) begin
         out_index_ff <= cmd.out_index;
         out_value_ff <= FIELD_WIDTH'(sat_value);
         out_last_ff  <= (cmd.out_index == LAST_INDEX);
      end
   end

   assign status.sum_ready = done_ff;
   assign rsp_result_index = out_index_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ----- hdl/mm4_control.sv -----
// Controller: accepts words, sequences element and term counters, hands out results.
module mm4_control (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mm4_pkg::CMD_WIDTH-1:0]     req_command,
   input  logic [mm4_pkg::INDEX_WIDTH-1:0]   req_element_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mm4_pkg::cmd_type                  cmd,
   input  mm4_pkg::status_type               status
);
   import mm4_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [INDEX_WIDTH-1:0] elem_ff, elem_in;
   logic [DIM_BITS-1:0]    k_ff, k_in;
   logic                   req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_take  = req_valid && req_ready;

   // Commands to the datapath
   always_comb begin
      cmd.wr_left       = req_take && (req_command == CMD_WRITE_LEFT);
      cmd.wr_right      = req_take && (req_command == CMD_WRITE_RIGHT);
      cmd.wr_index      = req_element_index;
      cmd.rd_en         = (state_ff == ST_MAC);
      // left(row, k) at k*DIM+row, right(k, col) at col*DIM+k
      cmd.rd_left_addr  = {k_ff, elem_ff[DIM_BITS-1:0]};
      cmd.rd_right_addr = {elem_ff[INDEX_WIDTH-1:DIM_BITS], k_ff};
      cmd.first         = (k_ff == '0);
      cmd.final_term    = (k_ff == LAST_K);
      cmd.out_index     = elem_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      elem_in  = elem_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_command == CMD_MULTIPLY)) begin
               elem_in  = '0;
               k_in     = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            k_in = k_ff + 1'b1;
            if (k_ff == LAST_K) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.sum_ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (elem_ff == LAST_INDEX) begin
                  state_in = ST_IDLE;
               end else begin
                  elem_in  = elem_ff + 1'b1;
                  k_in     = '0;
                  state_in = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         elem_ff  <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         elem_ff  <= elem_in;
         k_ff     <= k_in;
      end
   end

endmodule

// ----- hdl/matrix4_multiply.sv -----
// Top level of the 4x4 signed fixed-point matrix multiplier.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | command, element_index, element_value
//   rsp_    | out       | rsp_valid / rsp_ready | result_index, result_value, last
//
// A write word is stored in its element store as it is taken. A multiply word runs
// one shared 32x32 multiplier over four terms per element: the four term reads,
// the operand, product and sum registers, then the result register offered on rsp_,
// which holds while rsp_ready stays low. No new word is taken while a multiply runs.
// Synchronous reset returns the controller to idle; matrix contents are not cleared.
module matrix4_multiply (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mm4_pkg::CMD_WIDTH-1:0]          req_command,
   input  logic [mm4_pkg::INDEX_WIDTH-1:0]        req_element_index,
   input  logic signed [mm4_pkg::FIELD_WIDTH-1:0] req_element_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mm4_pkg::INDEX_WIDTH-1:0]        rsp_result_index,
   output logic signed [mm4_pkg::FIELD_WIDTH-1:0] rsp_result_value,
   output logic                                   rsp_last
);
   import mm4_pkg::*;

   cmd_type    cmd;
   status_type status;

   mm4_control u_control (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_element_index (req_element_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .cmd               (cmd),
      .status            (status)
   );

   mm4_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_element_value (req_element_value),
      .status            (status),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_value  (rsp_result_value),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- hdl/mm4_checker.sv -----
// Port-level checks for the matrix multiplier, bound to the top level.
module mm4_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic [mm4_pkg::CMD_WIDTH-1:0]          req_command,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [mm4_pkg::INDEX_WIDTH-1:0]        rsp_result_index,
   input logic signed [mm4_pkg::FIELD_WIDTH-1:0] rsp_result_value,
   input logic                                   rsp_last
);
   import mm4_pkg::*;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_index)
         && $stable(rsp_result_value) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // No result is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The block never takes a word while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while result pending");

   // Last element of a run returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("not idle after last element");

   // A multiply word starts a run
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_MULTIPLY) |=> !req_ready)
      else $error("ready during multiply run");

endmodule

bind matrix4_multiply mm4_checker u_mm4_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_index (rsp_result_index),
   .rsp_result_value (rsp_result_value),
   .rsp_last         (rsp_last)
);
